[hdl/lpmd_pkg.sv]
// Shared types and constants of the length-prefixed message deframer.
// Holds the item structs, the role and error codes and the queue sizing.
// No dependencies.
package lpmd_pkg;

  localparam int unsigned PAYLOAD_LENGTH_BYTES = 4;
  localparam int unsigned PL_LEN_W = 8 * PAYLOAD_LENGTH_BYTES;
  localparam int unsigned ID_LEN_BYTES = 2;
  localparam int unsigned ID_LEN_W = 8 * ID_LEN_BYTES;
  localparam int unsigned HDR_IDX_W = 2;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_DIGIT_LO = 8'd48;
  localparam logic [7:0] CHAR_DIGIT_HI = 8'd57;
  localparam logic [7:0] CHAR_UPPER_LO = 8'd65;
  localparam logic [7:0] CHAR_UPPER_HI = 8'd90;
  localparam logic [7:0] CHAR_LOWER_LO = 8'd97;
  localparam logic [7:0] CHAR_LOWER_HI = 8'd122;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'd95;

  typedef logic [HDR_IDX_W-1:0] hdr_idx_t;
  typedef logic [ID_LEN_W-1:0] id_len_t;
  typedef logic [PL_LEN_W-1:0] pl_len_t;
  typedef logic [QUEUE_PTR_W-1:0] queue_ptr_t;
  typedef logic [QUEUE_CNT_W-1:0] queue_cnt_t;

  typedef enum logic [2:0] {
    ROLE_IDLEN   = 3'd0,
    ROLE_IDCHAR  = 3'd1,
    ROLE_PLLEN   = 3'd2,
    ROLE_PAYLOAD = 3'd3,
    ROLE_EXCESS  = 3'd4
  } byte_role_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_BADID  = 2'd1,
    ERR_SHORT  = 2'd2,
    ERR_EXCESS = 2'd3
  } err_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_packet;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] byte_role;
    logic       packet_done;
    logic       packet_ok;
    logic [1:0] error_code;
  } out_item_t;

  typedef struct packed {
    logic [7:0] data;
    byte_role_e role;
    logic       last;
    err_e       err;
  } tag_t;

endpackage

[hdl/lpmd_front.sv]
// Front end of the deframer: parses the frame and tags each byte with its role and verdict.
// Holds the parse state; pushes one tag per accepted transfer into the queue.
// Depends on lpmd_pkg.
module lpmd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lpmd_pkg::in_item_t in_item_i,
  input  logic               q_ready_i,
  output logic               tag_valid_o,
  output lpmd_pkg::tag_t     tag_o
);

  lpmd_pkg::byte_role_e phase_q, phase_d;
  lpmd_pkg::hdr_idx_t   hdr_idx_q, hdr_idx_d;
  lpmd_pkg::id_len_t    id_left_q, id_left_d, id_shift;
  lpmd_pkg::pl_len_t    pl_left_q, pl_left_d, pl_shift;
  lpmd_pkg::err_e       first_err_q, first_err_d, err_n;
  lpmd_pkg::byte_role_e role;
  logic [lpmd_pkg::ID_LEN_W+7:0] id_cat;
  logic [lpmd_pkg::PL_LEN_W+7:0] pl_cat;
  logic [7:0] b;
  logic last;
  logic accept;

  function automatic logic id_char_ok(input logic [7:0] c);
    id_char_ok = (c >= lpmd_pkg::CHAR_DIGIT_LO && c <= lpmd_pkg::CHAR_DIGIT_HI) ||
                 (c >= lpmd_pkg::CHAR_UPPER_LO && c <= lpmd_pkg::CHAR_UPPER_HI) ||
                 (c >= lpmd_pkg::CHAR_LOWER_LO && c <= lpmd_pkg::CHAR_LOWER_HI) ||
                 (c == lpmd_pkg::CHAR_UNDERSCORE);
  endfunction

  assign b = in_item_i.in_byte;
  assign last = in_item_i.end_of_packet;
  assign in_ready_o = q_ready_i;
  assign accept = in_valid_i && q_ready_i;
  assign tag_valid_o = in_valid_i;

  assign id_cat = {id_left_q, b};
  assign pl_cat = {pl_left_q, b};
  assign id_shift = id_cat[lpmd_pkg::ID_LEN_W-1:0];
  assign pl_shift = pl_cat[lpmd_pkg::PL_LEN_W-1:0];

  always_comb begin
    phase_d   = phase_q;
    hdr_idx_d = hdr_idx_q;
    id_left_d = id_left_q;
    pl_left_d = pl_left_q;
    err_n     = first_err_q;
    role      = lpmd_pkg::ROLE_EXCESS;
    unique case (phase_q)
      lpmd_pkg::ROLE_IDLEN: begin
        role      = lpmd_pkg::ROLE_IDLEN;
        id_left_d = id_shift;
        hdr_idx_d = hdr_idx_q + lpmd_pkg::hdr_idx_t'(1);
        if (hdr_idx_q == lpmd_pkg::hdr_idx_t'(lpmd_pkg::ID_LEN_BYTES - 1)) begin
          hdr_idx_d = '0;
          phase_d = (id_shift == '0) ? lpmd_pkg::ROLE_PLLEN : lpmd_pkg::ROLE_IDCHAR;
        end
      end
      lpmd_pkg::ROLE_IDCHAR: begin
        role = lpmd_pkg::ROLE_IDCHAR;
        if (!id_char_ok(b) && err_n == lpmd_pkg::ERR_NONE) begin
          err_n = lpmd_pkg::ERR_BADID;
        end
        id_left_d = id_left_q - lpmd_pkg::id_len_t'(1);
        if (id_left_q == lpmd_pkg::id_len_t'(1)) begin
          phase_d = lpmd_pkg::ROLE_PLLEN;
        end
      end
      lpmd_pkg::ROLE_PLLEN: begin
        role      = lpmd_pkg::ROLE_PLLEN;
        pl_left_d = pl_shift;
        hdr_idx_d = hdr_idx_q + lpmd_pkg::hdr_idx_t'(1);
        if (hdr_idx_q == lpmd_pkg::hdr_idx_t'(lpmd_pkg::PAYLOAD_LENGTH_BYTES - 1)) begin
          hdr_idx_d = '0;
          phase_d = (pl_shift == '0) ? lpmd_pkg::ROLE_EXCESS : lpmd_pkg::ROLE_PAYLOAD;
        end
      end
      lpmd_pkg::ROLE_PAYLOAD: begin
        role      = lpmd_pkg::ROLE_PAYLOAD;
        pl_left_d = pl_left_q - lpmd_pkg::pl_len_t'(1);
        if (pl_left_q == lpmd_pkg::pl_len_t'(1)) begin
          phase_d = lpmd_pkg::ROLE_EXCESS;
        end
      end
      default: begin
        role = lpmd_pkg::ROLE_EXCESS;
        if (err_n == lpmd_pkg::ERR_NONE) begin
          err_n = lpmd_pkg::ERR_EXCESS;
        end
        phase_d = lpmd_pkg::ROLE_EXCESS;
      end
    endcase

    if (last && phase_d != lpmd_pkg::ROLE_EXCESS && err_n == lpmd_pkg::ERR_NONE) begin
      err_n = lpmd_pkg::ERR_SHORT;
    end

    first_err_d = err_n;
    if (last) begin
      phase_d     = lpmd_pkg::ROLE_IDLEN;
      hdr_idx_d   = '0;
      id_left_d   = '0;
      pl_left_d   = '0;
      first_err_d = lpmd_pkg::ERR_NONE;
    end
  end

  always_comb begin
    tag_o.data = b;
    tag_o.role = role;
    tag_o.last = last;
    tag_o.err  = last ? err_n : lpmd_pkg::ERR_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= lpmd_pkg::ROLE_IDLEN;
      hdr_idx_q   <= '0;
      id_left_q   <= '0;
      pl_left_q   <= '0;
      first_err_q <= lpmd_pkg::ERR_NONE;
    end else if (accept) begin
      phase_q     <= phase_d;
      hdr_idx_q   <= hdr_idx_d;
      id_left_q   <= id_left_d;
      pl_left_q   <= pl_left_d;
      first_err_q <= first_err_d;
    end
  end

endmodule

[hdl/lpmd_queue.sv]
// Short first-in first-out queue of byte tags between the front and back ends.
// A push and a pop may happen in the same cycle.
// Depends on lpmd_pkg.
module lpmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  lpmd_pkg::tag_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output lpmd_pkg::tag_t pop_data_o
);

  lpmd_pkg::tag_t       entry_q [lpmd_pkg::QUEUE_DEPTH];
  lpmd_pkg::queue_ptr_t wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  lpmd_pkg::queue_cnt_t count_q, count_d;
  logic push, pop;

  assign push_ready_o = (count_q != lpmd_pkg::queue_cnt_t'(lpmd_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + lpmd_pkg::queue_ptr_t'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + lpmd_pkg::queue_ptr_t'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + lpmd_pkg::queue_cnt_t'(1);
    end else if (pop && !push) begin
      count_d = count_q - lpmd_pkg::queue_cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[hdl/lpmd_back.sv]
// Back end of the deframer: turns queued tags into result items in an output register.
// Derives the packet verdict and holds the result while the receiver stalls.
// Depends on lpmd_pkg.
module lpmd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tag_valid_i,
  output logic                tag_ready_o,
  input  lpmd_pkg::tag_t      tag_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lpmd_pkg::out_item_t out_item_o
);

  logic                out_valid_q, out_valid_d;
  lpmd_pkg::out_item_t out_item_q, out_item_d;
  logic load;

  assign tag_ready_o = !out_valid_q || out_ready_i;
  assign load = tag_valid_i && tag_ready_o;

  always_comb begin
    out_item_d.out_byte    = tag_i.data;
    out_item_d.byte_role   = tag_i.role;
    out_item_d.packet_done = tag_i.last;
    out_item_d.packet_ok   = tag_i.last && (tag_i.err == lpmd_pkg::ERR_NONE);
    out_item_d.error_code  = tag_i.err;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[hdl/length_prefixed_message_deframer_top.sv]
// Top level of the length-prefixed message deframer.
// Instantiates lpmd_front, lpmd_queue and lpmd_back; depends on lpmd_pkg.
//
// Usage: packet bytes enter on the input channel (in_valid_i, in_ready_o, in_item_i),
// one byte per transfer, with end_of_packet set on the final byte. Every byte
// leaves on the output channel (out_valid_o, out_ready_i, out_item_o) tagged with
// its role in the frame. The transfer that carries the final byte also carries
// the verdict: packet_ok and error_code (bad ID character, truncated, excess bytes).
// The front end parses each byte as it is accepted and pushes a tag into a
// two-entry queue; the back end moves tags into the output register.
// An accepted byte's tag is written into the queue and then moved into the output
// register when that register is free, and held there until the receiver takes it.
// Throughput is one byte per cycle, limited only by the output register that
// accepts a new tag in every cycle in which the receiver takes the old one.
// When the receiver stalls, the output holds its result and the queue fills;
// in_ready_o drops once both queue entries are occupied.
// Reset empties the queue and the output register and returns the parser to
// the start of a frame. After every final byte the parser also restarts.
module length_prefixed_message_deframer_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lpmd_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lpmd_pkg::out_item_t out_item_o
);

  logic           push_valid, push_ready, pop_valid, pop_ready;
  lpmd_pkg::tag_t push_tag, pop_tag;

  lpmd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .q_ready_i   (push_ready),
    .tag_valid_o (push_valid),
    .tag_o       (push_tag)
  );

  lpmd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_tag),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_tag)
  );

  lpmd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_valid_i (pop_valid),
    .tag_ready_o (pop_ready),
    .tag_i       (pop_tag),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

[hdl/lpmd_checker.sv]
// Port-level checks of the deframer's output channel, bound to the top level.
// Covers output stalls and the consistency of the packet verdict fields.
// Depends on lpmd_pkg and length_prefixed_message_deframer_top.
module lpmd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input lpmd_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input lpmd_pkg::out_item_t out_item_o
);

  logic in_xfer;

  assign in_xfer = in_valid_i && in_ready_o && (in_item_i.in_byte == in_item_i.in_byte);

  // A stalled result stays in place until its transfer completes.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output result changed while stalled");

  a_ok_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.packet_ok ==
      (out_item_o.packet_done && out_item_o.error_code == lpmd_pkg::ERR_NONE))
    else $error("packet_ok disagrees with the verdict");

  a_err_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.packet_done |-> out_item_o.error_code == lpmd_pkg::ERR_NONE)
    else $error("error reported on a byte that does not end a packet");

  a_excess_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.packet_done &&
    out_item_o.error_code == lpmd_pkg::ERR_EXCESS |->
      out_item_o.byte_role == lpmd_pkg::ROLE_EXCESS)
    else $error("excess verdict on a byte inside the frame");

  a_short_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.packet_done &&
    out_item_o.error_code == lpmd_pkg::ERR_SHORT && !in_xfer |->
      out_item_o.byte_role != lpmd_pkg::ROLE_EXCESS)
    else $error("truncated verdict on a byte beyond the frame");

endmodule

bind length_prefixed_message_deframer_top lpmd_checker u_lpmd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

[tb/length_prefixed_message_deframer_top_tb.sv]
// Testbench for length_prefixed_message_deframer_top: drives framed, broken and noisy
// packets under random sender gaps and receiver stalls, checks every output transfer
// against a script item or local frame parser. Needs only lpmd_pkg and the top level.
module length_prefixed_message_deframer_top_tb;

  typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;
  typedef enum int {PKT_GOOD, PKT_BAD_ID, PKT_EXCESS, PKT_TRUNC, PKT_NOISE} pkt_kind_e;

  typedef struct {
    logic [7:0]          data;
    logic                eop;
    logic                typed;
    lpmd_pkg::out_item_t want;
  } script_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  lpmd_pkg::in_item_t  in_item_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  lpmd_pkg::out_item_t out_item_o;

  lpmd_pkg::byte_role_e parse_ph;
  lpmd_pkg::hdr_idx_t   hdr_idx;
  lpmd_pkg::id_len_t    id_left;
  lpmd_pkg::pl_len_t    pl_left;
  lpmd_pkg::err_e       first_err;

  lpmd_pkg::out_item_t  pending_tags[$];
  lpmd_pkg::out_item_t  due_tag;
  logic [7:0] frame_q[$];
  int         error_count = 0;
  int         bytes_sent = 0;
  int         frames_sent = 0;
  int         transfers_seen = 0;
  int         verdicts_seen = 0;
  int         good_verdicts = 0;
  int         burst_left = 0;
  rx_mode_e   rx_mode = RX_STREAM;
  int         rx_epoch = 0;
  int         rx_tick = 0;

  script_row_t script [26] = '{
    '{8'h00, 1'b0, 1'b1, '{8'h00, lpmd_pkg::ROLE_IDLEN, 1'b0, 1'b0, lpmd_pkg::ERR_NONE}},
    '{8'h00, 1'b0, 1'b1, '{8'h00, lpmd_pkg::ROLE_IDLEN, 1'b0, 1'b0, lpmd_pkg::ERR_NONE}},
    '{8'h00, 1'b0, 1'b1, '{8'h00, lpmd_pkg::ROLE_PLLEN, 1'b0, 1'b0, lpmd_pkg::ERR_NONE}},
    '{8'h00, 1'b0, 1'b1, '{8'h00, lpmd_pkg::ROLE_PLLEN, 1'b0, 1'b0, lpmd_pkg::ERR_NONE}},
    '{8'h00, 1'b0, 1'b1, '{8'h00, lpmd_pkg::ROLE_PLLEN, 1'b0, 1'b0, lpmd_pkg::ERR_NONE}},
    '{8'h00, 1'b1, 1'b1, '{8'h00, lpmd_pkg::ROLE_PLLEN, 1'b1, 1'b1, lpmd_pkg::ERR_NONE}},
    '{8'hFF, 1'b0, 1'b1, '{8'hFF, lpmd_pkg::ROLE_IDLEN, 1'b0, 1'b0, lpmd_pkg::ERR_NONE}},
    '{8'hFF, 1'b0, 1'b1, '{8'hFF, lpmd_pkg::ROLE_IDLEN, 1'b0, 1'b0, lpmd_pkg::ERR_NONE}},
    '{8'h00, 1'b1, 1'b1, '{8'h00, lpmd_pkg::ROLE_IDCHAR, 1'b1, 1'b0, lpmd_pkg::ERR_BADID}},
    '{8'h7A, 1'b1, 1'b1, '{8'h7A, lpmd_pkg::ROLE_IDLEN, 1'b1, 1'b0, lpmd_pkg::ERR_SHORT}},
    '{8'h00, 1'b0, 1'b1, '{8'h00, lpmd_pkg::ROLE_IDLEN, 1'b0, 1'b0, lpmd_pkg::ERR_NONE}},
    '{8'h00, 1'b0, 1'b1, '{8'h00, lpmd_pkg::ROLE_IDLEN, 1'b0, 1'b0, lpmd_pkg::ERR_NONE}},
    '{8'h00, 1'b0, 1'b1, '{8'h00, lpmd_pkg::ROLE_PLLEN, 1'b0, 1'b0, lpmd_pkg::ERR_NONE}},
    '{8'h00, 1'b0, 1'b1, '{8'h00, lpmd_pkg::ROLE_PLLEN, 1'b0, 1'b0, lpmd_pkg::ERR_NONE}},
    '{8'h00, 1'b0, 1'b1, '{8'h00, lpmd_pkg::ROLE_PLLEN, 1'b0, 1'b0, lpmd_pkg::ERR_NONE}},
    '{8'h00, 1'b0, 1'b1, '{8'h00, lpmd_pkg::ROLE_PLLEN, 1'b0, 1'b0, lpmd_pkg::ERR_NONE}},
    '{8'hFF, 1'b1, 1'b1, '{8'hFF, lpmd_pkg::ROLE_EXCESS, 1'b1, 1'b0, lpmd_pkg::ERR_EXCESS}},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h02, 1'b0, 1'b0, '0},
    '{8'h7A, 1'b0, 1'b0, '0},
    '{8'h5F, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h80, 1'b1, 1'b0, '0}
  };

  length_prefixed_message_deframer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic void clear_parser();
    parse_ph = lpmd_pkg::ROLE_IDLEN;
    hdr_idx = '0;
    id_left = '0;
    pl_left = '0;
    first_err = lpmd_pkg::ERR_NONE;
  endfunction

  function automatic lpmd_pkg::out_item_t deframe_byte(input logic [7:0] b, input logic eop);
    lpmd_pkg::byte_role_e role;
    lpmd_pkg::hdr_idx_t   taken;
    lpmd_pkg::err_e       verdict;
    lpmd_pkg::out_item_t  tag;
    role = parse_ph;
    verdict = lpmd_pkg::ERR_NONE;
    case (role)
      lpmd_pkg::ROLE_IDLEN: begin
        id_left = {id_left[7:0], b};
        hdr_idx = hdr_idx + 1'b1;
        if (hdr_idx == 2'd2) begin
          hdr_idx = '0;
          parse_ph = (id_left == '0) ? lpmd_pkg::ROLE_PLLEN : lpmd_pkg::ROLE_IDCHAR;
        end
      end
      lpmd_pkg::ROLE_IDCHAR: begin
        if (!((b >= lpmd_pkg::CHAR_DIGIT_LO && b <= lpmd_pkg::CHAR_DIGIT_HI) ||
              (b >= lpmd_pkg::CHAR_UPPER_LO && b <= lpmd_pkg::CHAR_UPPER_HI) ||
              (b >= lpmd_pkg::CHAR_LOWER_LO && b <= lpmd_pkg::CHAR_LOWER_HI) ||
              b == lpmd_pkg::CHAR_UNDERSCORE) &&
            first_err == lpmd_pkg::ERR_NONE) begin
          first_err = lpmd_pkg::ERR_BADID;
        end
        id_left = id_left - 1'b1;
        if (id_left == '0) parse_ph = lpmd_pkg::ROLE_PLLEN;
      end
      lpmd_pkg::ROLE_PLLEN: begin
        pl_left = {pl_left[lpmd_pkg::PL_LEN_W-9:0], b};
        taken = hdr_idx;
        hdr_idx = hdr_idx + 1'b1;
        if (int'(taken) + 1 >= lpmd_pkg::PAYLOAD_LENGTH_BYTES) begin
          hdr_idx = '0;
          parse_ph = (pl_left == '0) ? lpmd_pkg::ROLE_EXCESS : lpmd_pkg::ROLE_PAYLOAD;
        end
      end
      lpmd_pkg::ROLE_PAYLOAD: begin
        pl_left = pl_left - 1'b1;
        if (pl_left == '0) parse_ph = lpmd_pkg::ROLE_EXCESS;
      end
      default: begin
        if (first_err == lpmd_pkg::ERR_NONE) first_err = lpmd_pkg::ERR_EXCESS;
        parse_ph = lpmd_pkg::ROLE_EXCESS;
      end
    endcase
    if (eop) begin
      if (parse_ph != lpmd_pkg::ROLE_EXCESS && first_err == lpmd_pkg::ERR_NONE) begin
        first_err = lpmd_pkg::ERR_SHORT;
      end
      verdict = first_err;
    end
    tag.out_byte = b;
    tag.byte_role = role;
    tag.packet_done = eop;
    tag.packet_ok = eop && verdict == lpmd_pkg::ERR_NONE;
    tag.error_code = verdict;
    if (eop) clear_parser();
    return tag;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic eop, input logic typed,
                           input lpmd_pkg::out_item_t typed_tag);
    lpmd_pkg::out_item_t predicted;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_item_i <= '{in_byte: b, end_of_packet: eop};
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predicted = deframe_byte(b, eop);
    pending_tags.push_back(typed ? typed_tag : predicted);
    bytes_sent++;
    if (eop) frames_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic drain_pending();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_tags.size() != 0) @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(negedge clk_i) begin
    if (rx_epoch == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_epoch <= $urandom_range(20, 80);
    end else begin
      rx_epoch <= rx_epoch - 1;
    end
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RX_STREAM:   out_ready_i <= 1'b1;
      RX_COIN:     out_ready_i <= 1'($urandom_range(0, 1));
      RX_SPARSE:   out_ready_i <= ($urandom_range(0, 3) == 0);
      default:     out_ready_i <= (rx_tick % 7) > 2;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      transfers_seen++;
      if (pending_tags.size() == 0) begin
        $error("output transfer with nothing expected: byte %0h", out_item_o.out_byte);
        error_count++;
      end else begin
        due_tag = pending_tags.pop_front();
        check_field("out_byte", due_tag.out_byte, out_item_o.out_byte);
        check_field("byte_role", 8'(due_tag.byte_role), 8'(out_item_o.byte_role));
        check_field("packet_done", 8'(due_tag.packet_done), 8'(out_item_o.packet_done));
        check_field("packet_ok", 8'(due_tag.packet_ok), 8'(out_item_o.packet_ok));
        check_field("error_code", 8'(due_tag.error_code), 8'(out_item_o.error_code));
        if (due_tag.packet_done) begin
          verdicts_seen++;
          if (due_tag.packet_ok) good_verdicts++;
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [15:0]   id_len;
    logic [31:0]   pl_len;
    pkt_kind_e     kind;
    int unsigned   pick;
    int            pos;
    int            next_drain;
    clear_parser();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (script[r]) push_byte(script[r].data, script[r].eop, script[r].typed, script[r].want);
    drain_pending();

    next_drain = bytes_sent + 250;
    while (bytes_sent < 1000) begin
      pick = $urandom_range(0, 99);
      kind = (pick < 55) ? PKT_GOOD : (pick < 67) ? PKT_BAD_ID : (pick < 79) ? PKT_EXCESS :
             (pick < 91) ? PKT_TRUNC : PKT_NOISE;
      id_len = ($urandom_range(0, 49) == 0) ? 16'($urandom_range(256, 300))
                                            : 16'($urandom_range(0, 8));
      pl_len = ($urandom_range(0, 49) == 0) ? 32'($urandom_range(256, 400))
                                            : 32'($urandom_range(0, 12));
      frame_q.delete();
      frame_q.push_back(id_len[15:8]);
      frame_q.push_back(id_len[7:0]);
      for (int i = 0; i < int'(id_len); i++) begin
        pick = $urandom_range(0, 62);
        if (pick < 10) frame_q.push_back(lpmd_pkg::CHAR_DIGIT_LO + 8'(pick));
        else if (pick < 36) frame_q.push_back(lpmd_pkg::CHAR_UPPER_LO + 8'(pick - 10));
        else if (pick < 62) frame_q.push_back(lpmd_pkg::CHAR_LOWER_LO + 8'(pick - 36));
        else frame_q.push_back(lpmd_pkg::CHAR_UNDERSCORE);
      end
      for (int i = lpmd_pkg::PAYLOAD_LENGTH_BYTES - 1; i >= 0; i--) begin
        frame_q.push_back(pl_len[8*i +: 8]);
      end
      for (int i = 0; i < int'(pl_len); i++) frame_q.push_back(8'($urandom_range(0, 255)));
      case (kind)
        PKT_BAD_ID: begin
          if (id_len != 0) begin
            pos = $urandom_range(2, 1 + int'(id_len));
            frame_q[pos] = 8'($urandom_range(0, 255));
          end
        end
        PKT_EXCESS: begin
          repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom_range(0, 255)));
        end
        PKT_TRUNC: begin
          pos = $urandom_range(1, frame_q.size() - 1);
          while (frame_q.size() > pos) void'(frame_q.pop_back());
        end
        PKT_NOISE: begin
          frame_q.delete();
          repeat ($urandom_range(1, 10)) frame_q.push_back(8'($urandom_range(0, 255)));
        end
        default: ;
      endcase
      for (int i = 0; i < frame_q.size(); i++) begin
        push_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, '0);
      end
      if (bytes_sent >= next_drain) begin
        drain_pending();
        next_drain = bytes_sent + 250;
      end
    end

    drain_pending();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d bytes in %0d packets; checked %0d output transfers.",
             bytes_sent, frames_sent, transfers_seen);
    $display("Verdicts: %0d packets framed correctly, %0d flagged with an error.",
             good_verdicts, verdicts_seen - good_verdicts);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
hdl/lpmd_pkg.sv
hdl/lpmd_front.sv
hdl/lpmd_queue.sv
hdl/lpmd_back.sv
hdl/length_prefixed_message_deframer_top.sv
hdl/lpmd_checker.sv
tb/length_prefixed_message_deframer_top_tb.sv
